@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/upc_pkg.sv @@
// ----------------------------------------------------------------------------
// upc_pkg
// Types and constants of the UDP payload pattern counter.
// ----------------------------------------------------------------------------
package upc_pkg;

	// Pattern geometry
	localparam int PATTERN_LEN = 7;
	localparam int WIN_W       = 8 * PATTERN_LEN;
	localparam int PATTERN_W   = 56;
	localparam int COUNT_W     = 64;
	localparam int POS_W       = 16;

	localparam logic [PATTERN_W-1:0] PATTERN_RESET = 56'h6578616D706C65;

	// Frame offsets and length thresholds
	localparam logic [POS_W-1:0] POS_MAX          = '1;
	localparam logic [POS_W-1:0] POS_TYPE_HI      = 16'd12;
	localparam logic [POS_W-1:0] POS_TYPE_LO      = 16'd13;
	localparam logic [POS_W-1:0] POS_PROTO        = 16'd23;
	localparam logic [POS_W-1:0] LEN_MIN_ETH      = 16'd14;
	localparam logic [POS_W-1:0] LEN_MIN_IP       = 16'd34;
	localparam logic [POS_W-1:0] PAYLOAD_START    = 16'd42;
	localparam logic [POS_W-1:0] MATCH_START      = POS_W'(42 + PATTERN_LEN - 1);

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;

	// Input item: one frame byte
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	// Result item: one per frame
	typedef struct packed {
		logic               verdict;
		logic               pattern_matched;
		logic [COUNT_W-1:0] match_total;
	} out_item_t;

	// Per-frame decision handed from parser to result stage
	typedef struct packed {
		logic verdict;
		logic hit;
	} frame_verdict_t;

	// Pattern register fitted to the window width; bytes above 56 bits read zero
	function automatic logic [WIN_W-1:0] fit_pattern(input logic [PATTERN_W-1:0] p);
		logic [63:0] ext;
		ext = {8'h00, p};
		return ext[WIN_W-1:0];
	endfunction

endpackage

@@ rtl/upc_frame_parser.sv @@
// ----------------------------------------------------------------------------
// upc_frame_parser
// Per-frame header capture, pattern window and verdict logic.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module upc_frame_parser (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 advance,
	input  upc_pkg::in_item_t                    item,
	input  logic [upc_pkg::PATTERN_W-1:0]        match_pattern,
	output upc_pkg::frame_verdict_t              decision
);

	logic [upc_pkg::POS_W-1:0] pos_q;
	logic [15:0]               type_q;
	logic [7:0]                proto_q;
	logic [upc_pkg::WIN_W-1:0] win_q;
	logic                      seen_q;

	logic [upc_pkg::POS_W-1:0] len_next;
	logic [15:0]               type_next;
	logic [7:0]                proto_next;
	logic [upc_pkg::WIN_W-1:0] win_next;
	logic                      seen_next;

	// Header capture and window for the byte in the input register
	always_comb begin
		type_next  = type_q;
		proto_next = proto_q;
		if (pos_q == upc_pkg::POS_TYPE_HI) begin
			type_next = {item.data_byte, type_q[7:0]};
		end else if (pos_q == upc_pkg::POS_TYPE_LO) begin
			type_next = {type_q[15:8], item.data_byte};
		end else if (pos_q == upc_pkg::POS_PROTO) begin
			proto_next = item.data_byte;
		end
		win_next  = upc_pkg::WIN_W'({win_q, item.data_byte});
		seen_next = seen_q ||
			((pos_q >= upc_pkg::MATCH_START) &&
			 (win_next == upc_pkg::fit_pattern(match_pattern)));
		len_next  = (pos_q == upc_pkg::POS_MAX) ? pos_q : pos_q + 1'b1;
	end

	// Verdict in priority order: short, non-IPv4, short, non-UDP, short, pass
	always_comb begin
		decision.verdict = 1'b0;
		decision.hit     = 1'b0;
		if (len_next < upc_pkg::LEN_MIN_ETH) begin
			decision.verdict = 1'b1;
		end else if (type_next != upc_pkg::ETHERTYPE_IPV4) begin
			decision.verdict = 1'b0;
		end else if (len_next < upc_pkg::LEN_MIN_IP) begin
			decision.verdict = 1'b1;
		end else if (proto_next != upc_pkg::PROTO_UDP) begin
			decision.verdict = 1'b0;
		end else if (len_next < upc_pkg::PAYLOAD_START) begin
			decision.verdict = 1'b1;
		end else begin
			decision.hit = seen_next;
		end
	end

	// Frame state; cleared after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			type_q  <= '0;
			proto_q <= '0;
			win_q   <= '0;
			seen_q  <= 1'b0;
		end else if (advance) begin
			if (item.last_byte) begin
				pos_q   <= '0;
				type_q  <= '0;
				proto_q <= '0;
				win_q   <= '0;
				seen_q  <= 1'b0;
			end else begin
				pos_q   <= len_next;
				type_q  <= type_next;
				proto_q <= proto_next;
				win_q   <= win_next;
				seen_q  <= seen_next;
			end
		end
	end

	`ASSERT_NEXT(a_clear_after_last, clk, arst_n, advance && item.last_byte, (pos_q == '0) && !seen_q)
	`ASSERT_IMPL(a_seen_past_start, clk, arst_n, seen_q, pos_q > upc_pkg::MATCH_START)
	`ASSERT_IMPL(a_hit_not_drop, clk, arst_n, decision.hit, !decision.verdict)

endmodule

@@ rtl/upc_result_stage.sv @@
// ----------------------------------------------------------------------------
// upc_result_stage
// Matching-frame counter and the registered result slot.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module upc_result_stage (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  upc_pkg::frame_verdict_t decision,
	output logic                    slot_free,
	output logic                    out_valid,
	input  logic                    out_ready,
	output upc_pkg::out_item_t      out_data
);

	logic [upc_pkg::COUNT_W-1:0] count_q;
	logic [upc_pkg::COUNT_W-1:0] count_next;
	logic                        valid_q;
	upc_pkg::out_item_t          result_q;

	// Slot can take a result when empty or emptying this cycle
	assign slot_free  = !valid_q || out_ready;
	assign count_next = count_q + upc_pkg::COUNT_W'(decision.hit);

	// Control: counter and slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				count_q <= count_next;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Payload of the result slot
	always_ff @(posedge clk) begin
		if (load) begin
			result_q.verdict         <= decision.verdict;
			result_q.pattern_matched <= decision.hit;
			result_q.match_total     <= count_next;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = result_q;

	`ASSERT_NEXT(a_count_step, clk, arst_n, load, count_q == $past(count_q) + upc_pkg::COUNT_W'($past(decision.hit)))
	`ASSERT_NEXT(a_count_hold_stall, clk, arst_n, valid_q && !out_ready, $stable(count_q))
	`ASSERT_IMPL(a_load_needs_slot, clk, arst_n, load, slot_free)

endmodule

@@ rtl/udp_payload_pattern_counter.sv @@
// ----------------------------------------------------------------------------
// udp_payload_pattern_counter
// Counts UDP frames whose payload holds a configured 7-byte pattern.
// ----------------------------------------------------------------------------
// Frame bytes enter on the in channel (valid/ready), one byte per transfer in
// wire order, with last_byte set on the final byte. Each frame gives exactly
// one transfer on the out channel: a pass/drop verdict, a pattern flag and
// the running 64-bit count of matching frames.
// The cfg channel writes the 56-bit pattern (first byte in the top byte);
// it is always ready and should be written only while no frame is in flight.
// Throughput is one byte per clock unless a final byte waits for the result
// slot: an input register feeds single-pass header/window logic that writes
// the result register, which a final byte's result enters as it advances.
// When the out side stalls, non-final bytes keep flowing; a final byte waits
// in the input register until the result slot frees, and in_ready drops only
// then. Reset clears frame state, the counter and the pipeline, and restores
// the pattern to ASCII "example". No clearing pass is needed.
// ----------------------------------------------------------------------------
module udp_payload_pattern_counter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  upc_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output upc_pkg::out_item_t            out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [upc_pkg::PATTERN_W-1:0] cfg_data
);

	logic                          valid_s1;
	upc_pkg::in_item_t             item_s1;
	logic [upc_pkg::PATTERN_W-1:0] pattern_q;
	logic                          slot_free;
	logic                          advance;
	upc_pkg::frame_verdict_t       decision;

	// Input register moves on unless a final byte meets a full result slot
	assign advance   = valid_s1 && (!item_s1.last_byte || slot_free);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			pattern_q <= upc_pkg::PATTERN_RESET;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (cfg_valid) begin
				pattern_q <= cfg_data;
			end
		end
	end

	// Input payload register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	upc_frame_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.item          (item_s1),
		.match_pattern (pattern_q),
		.decision      (decision)
	);

	upc_result_stage u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && item_s1.last_byte),
		.decision  (decision),
		.slot_free (slot_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
